FILE: src/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// types, constants and the delivery function of the segment reorder block
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int REORDER_DEPTH = 16;
   localparam int CNT_W = $clog2(REORDER_DEPTH + 1);
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [23:0] MSG_MAX = 24'hFF_FFFF;

   localparam logic [2:0] KIND_DELIVERED = 3'd0;
   localparam logic [2:0] KIND_STASHED = 3'd1;
   localparam logic [2:0] KIND_DROPPED = 3'd2;
   localparam logic [2:0] KIND_IGNORED = 3'd3;
   localparam logic [2:0] KIND_FULL = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_CHECK,
      ST_EMIT,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] len;
      logic [3:0] flags;
      logic [7:0] tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tag;
      logic [31:0] seq;
      logic [15:0] trim;
      logic [15:0] useful;
      logic md;
      logic [23:0] size;
      logic closed;
      logic last;
   } res_type;

   typedef struct packed {
      res_type res;
      logic [31:0] exp_seq;
      logic [23:0] pend;
      logic closed;
   } dlv_type;

   function automatic res_type plain_res(logic [2:0] kind, entry_type e);
      res_type r;
      r = '0;
      r.kind = kind;
      r.tag = e.tag;
      r.seq = e.seq;
      return r;
   endfunction

   // trim, account and report one segment at or before the expected position
   function automatic dlv_type deliver(logic [31:0] exp_seq, logic [23:0] pend,
                                       entry_type e);
      dlv_type d;
      logic [31:0] back;
      logic [15:0] useful;
      logic [24:0] sum;
      logic [23:0] np;
      back = exp_seq - e.seq;
      d = '0;
      d.exp_seq = exp_seq;
      d.pend = pend;
      if (back > {16'd0, e.len} || (back == {16'd0, e.len} && e.flags == 4'd0)) begin
         d.res = plain_res(KIND_DROPPED, e);
      end else begin
         useful = e.len - back[15:0];
         sum = {1'b0, pend} + {9'd0, useful};
         np = (sum > {1'b0, MSG_MAX}) ? MSG_MAX : sum[23:0];
         d.res = plain_res(KIND_DELIVERED, e);
         d.res.trim = back[15:0];
         d.res.useful = useful;
         d.res.closed = e.flags[2];
         d.exp_seq = exp_seq + {16'd0, useful};
         if ((e.flags[1] || e.flags[2]) && np != 24'd0) begin
            d.res.md = 1'b1;
            d.res.size = np;
            np = 24'd0;
         end
         d.pend = e.flags[2] ? 24'd0 : np;
         d.closed = e.flags[2];
      end
      return d;
   endfunction

endpackage

FILE: src/ssr_cell.sv
// ----------------------------------------------------------------------------
// ssr_cell
// one slot of the sorted reorder chain
// ----------------------------------------------------------------------------
module ssr_cell import ssr_pkg::*; (
   input logic clock,
   input cell_ctl_type ctl,
   input logic [31:0] expected,
   input logic [31:0] seg_dist,
   input entry_type new_entry,
   input entry_type left_entry,
   input entry_type right_entry,
   input logic occupied,
   input logic left_lt,
   output entry_type entry,
   output logic lt,
   output logic dup_hit
);

   entry_type entry_ff, entry_in;
   logic [31:0] rel;
   logic at_slot;

   assign rel = entry_ff.seq - expected;
   assign lt = occupied && ((rel ^ SIGN_BIT) < (seg_dist ^ SIGN_BIT));
   // first slot not behind the new segment
   assign at_slot = !lt && left_lt;
   assign dup_hit = at_slot && occupied && entry_ff.seq == new_entry.seq &&
                    new_entry.len <= entry_ff.len && new_entry.flags == entry_ff.flags;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         entry_in = right_entry;
      end else if (ctl.insert && !lt) begin
         entry_in = at_slot ? new_entry : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: src/stream_segment_reorder_reassembly.sv
// ----------------------------------------------------------------------------
// stream_segment_reorder_reassembly
// receive reassembly and reorder buffer for a byte-sequenced stream
// ----------------------------------------------------------------------------
// usage
//   req_* carries one segment descriptor per transfer, rsp_* one result per
//   transfer; rsp_last marks the final result caused by a segment
//   a new segment is taken only when the previous one has finished all its
//   results; req_stall is high meanwhile
//   early, duplicate, full and after-end segments go from classify straight
//   to emit; in-order and stale ones pass through the check state first
//   each buffered segment drained or flushed behind an in-order or stale
//   segment passes through the drain or flush, check and emit states; the
//   sorted chain of cells moves one step for each drained or flushed segment
//   insert into the chain is done in parallel: every cell compares its distance
//   and either holds, takes the new segment or takes its neighbour
//   reset clears expected position, message byte count, end flag and fill count;
//   the chain contents are not cleared, the fill count masks them
//   when the receiver stalls, the result is held in the output register and
//   the sequencer waits in its emit state
// ----------------------------------------------------------------------------
module stream_segment_reorder_reassembly import ssr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [31:0] req_seg_seq,
   input logic [15:0] req_seg_len,
   input logic [3:0] req_seg_flags,
   input logic [7:0] req_seg_tag,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_out_tag,
   output logic [31:0] rsp_out_seq,
   output logic [15:0] rsp_trim_bytes,
   output logic [15:0] rsp_useful_len,
   output logic rsp_message_done,
   output logic [23:0] rsp_message_size,
   output logic rsp_stream_closed,
   output logic rsp_last
);

   state_type state_ff, state_in;

   // stream state
   logic [31:0] exp_ff, exp_in;
   logic [23:0] pend_ff, pend_in;
   logic ended_ff, ended_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // captured segment and staged result
   entry_type seg_ff, seg_in;
   res_type stage_ff, stage_in;

   // output register
   logic out_valid_ff, out_valid_in;
   res_type out_ff, out_in;

   // chain wiring
   entry_type ents [REORDER_DEPTH];
   logic [REORDER_DEPTH-1:0] lts, dups;
   cell_ctl_type ctl;
   logic [31:0] seg_dist;
   logic [31:0] head_rel;
   logic head_not_ahead;
   logic out_free;
   dlv_type dlv_seg, dlv_head;

   assign seg_dist = seg_ff.seq - exp_ff;
   assign head_rel = ents[0].seq - exp_ff;
   assign head_not_ahead = head_rel == 32'd0 || head_rel[31];
   assign out_free = !out_valid_ff || !rsp_stall;
   assign dlv_seg = deliver(exp_ff, pend_ff, seg_ff);
   assign dlv_head = deliver(exp_ff, pend_ff, ents[0]);

   genvar gi;
   generate
      for (gi = 0; gi < REORDER_DEPTH; gi++) begin : g_cell
         logic occ;
         logic left_lt;
         entry_type left_e, right_e;
         assign occ = CNT_W'(gi) < count_ff;
         if (gi == 0) begin : g_first
            assign left_lt = 1'b1;
            assign left_e = seg_ff;
         end else begin : g_mid
            assign left_lt = lts[gi-1];
            assign left_e = ents[gi-1];
         end
         if (gi == REORDER_DEPTH - 1) begin : g_end
            assign right_e = ents[gi];
         end else begin : g_inner
            assign right_e = ents[gi+1];
         end
         ssr_cell u_cell (
            .clock(clock),
            .ctl(ctl),
            .expected(exp_ff),
            .seg_dist(seg_dist),
            .new_entry(seg_ff),
            .left_entry(left_e),
            .right_entry(right_e),
            .occupied(occ),
            .left_lt(left_lt),
            .entry(ents[gi]),
            .lt(lts[gi]),
            .dup_hit(dups[gi])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (!ended_ff && (seg_dist == 32'd0 || seg_dist[31])) state_in = ST_CHECK;
            else state_in = ST_EMIT;
         end
         ST_CHECK: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (stage_ff.last) state_in = ST_IDLE;
               else if (ended_ff) state_in = ST_FLUSH;
               else state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_CHECK;
         ST_FLUSH: state_in = ST_CHECK;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_stall = state_ff != ST_IDLE;
      ctl = '0;
      exp_in = exp_ff;
      pend_in = pend_ff;
      ended_in = ended_ff;
      count_in = count_ff;
      seg_in = seg_ff;
      stage_in = stage_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            seg_in = '{seq: req_seg_seq, len: req_seg_len,
                       flags: req_seg_flags, tag: req_seg_tag};
         end
         ST_CLASSIFY: begin
            if (ended_ff) begin
               stage_in = plain_res(KIND_IGNORED, seg_ff);
               stage_in.last = 1'b1;
            end else if (seg_dist == 32'd0 || seg_dist[31]) begin
               stage_in = dlv_seg.res;
               exp_in = dlv_seg.exp_seq;
               pend_in = dlv_seg.pend;
               ended_in = dlv_seg.closed;
            end else begin
               if (|dups) begin
                  stage_in = plain_res(KIND_DROPPED, seg_ff);
               end else if (count_ff == CNT_W'(REORDER_DEPTH)) begin
                  stage_in = plain_res(KIND_FULL, seg_ff);
               end else begin
                  // sorted insert through the chain
                  ctl.insert = 1'b1;
                  count_in = count_ff + 1'b1;
                  stage_in = plain_res(KIND_STASHED, seg_ff);
               end
               stage_in.last = 1'b1;
            end
         end
         ST_CHECK: begin
            // after a close every entry left is flushed, otherwise only in-order heads
            if (ended_ff) stage_in.last = count_ff == '0;
            else stage_in.last = !(count_ff != '0 && head_not_ahead);
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = stage_ff;
            end
         end
         ST_DRAIN: begin
            stage_in = dlv_head.res;
            exp_in = dlv_head.exp_seq;
            pend_in = dlv_head.pend;
            ended_in = dlv_head.closed;
            ctl.pop = 1'b1;
            count_in = count_ff - 1'b1;
         end
         ST_FLUSH: begin
            stage_in = plain_res(KIND_IGNORED, ents[0]);
            ctl.pop = 1'b1;
            count_in = count_ff - 1'b1;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         exp_ff <= '0;
         pend_ff <= '0;
         ended_ff <= 1'b0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         exp_ff <= exp_in;
         pend_ff <= pend_in;
         ended_ff <= ended_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
      stage_ff <= stage_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_out_tag = out_ff.tag;
   assign rsp_out_seq = out_ff.seq;
   assign rsp_trim_bytes = out_ff.trim;
   assign rsp_useful_len = out_ff.useful;
   assign rsp_message_done = out_ff.md;
   assign rsp_message_size = out_ff.size;
   assign rsp_stream_closed = out_ff.closed;
   assign rsp_last = out_ff.last;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the segment reorder and reassembly block
// ----------------------------------------------------------------------------
// segments are offered on the req_ side and every result on the rsp_ side is
// checked against an in-bench model of the expected position, the message byte
// count, the end flag and the sorted store of early segments
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import ssr_pkg::*;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] tag;
      logic [31:0] seq;
      logic [15:0] trim;
      logic [15:0] useful;
      logic md;
      logic [23:0] size;
      logic closed;
      logic last;
   } segment_result_type;

   int error_count = 0;

   // one line per mismatch, and a count
   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   // -------------------------------------------------------------------------
   // reassembly scoreboard: predicts the results of each accepted segment
   // -------------------------------------------------------------------------
   class reassembly_scoreboard;
      logic [31:0] next_seq;
      logic [23:0] msg_bytes;
      bit ended;
      logic [31:0] st_seq[$];
      logic [15:0] st_len[$];
      logic [3:0] st_flags[$];
      logic [7:0] st_tag[$];
      segment_result_type pending_results[$];

      function new();
         next_seq = '0;
         msg_bytes = '0;
         ended = 0;
      endfunction

      function automatic bit behind(logic [31:0] d);
         return d == 32'd0 || d[31];
      endfunction

      function automatic void push_res(logic [2:0] k, logic [7:0] t, logic [31:0] s,
                                       logic [15:0] tr, logic [15:0] u, logic md,
                                       logic [23:0] sz, logic cl);
         segment_result_type r;
         r.kind = k; r.tag = t; r.seq = s; r.trim = tr; r.useful = u;
         r.md = md; r.size = sz; r.closed = cl; r.last = 0;
         pending_results.push_back(r);
      endfunction

      // trims and accounts one in-order segment; returns 1 on a delivered close
      function automatic bit take_in_order(logic [31:0] s, logic [15:0] l,
                                           logic [3:0] f, logic [7:0] t);
         logic [31:0] back;
         logic [15:0] u;
         logic [24:0] sum;
         logic md;
         logic [23:0] sz;
         back = next_seq - s;
         md = 0;
         sz = '0;
         if (back > {16'd0, l} || (back == {16'd0, l} && f == 4'd0)) begin
            push_res(KIND_DROPPED, t, s, 0, 0, 0, 0, 0);
            return 0;
         end
         u = l - back[15:0];
         next_seq = next_seq + {16'd0, u};
         sum = {1'b0, msg_bytes} + {9'd0, u};
         msg_bytes = (sum > {1'b0, MSG_MAX}) ? MSG_MAX : sum[23:0];
         if ((f[1] || f[2]) && msg_bytes != 0) begin
            md = 1;
            sz = msg_bytes;
            msg_bytes = '0;
         end
         push_res(KIND_DELIVERED, t, s, back[15:0], u, md, sz, f[2]);
         return f[2];
      endfunction

      function automatic void pop_store();
         void'(st_seq.pop_front()); void'(st_len.pop_front());
         void'(st_flags.pop_front()); void'(st_tag.pop_front());
      endfunction

      function automatic void note_segment(logic [31:0] s, logic [15:0] l,
                                           logic [3:0] f, logic [7:0] t);
         logic [31:0] d;
         int pos;
         bit cl;
         d = s - next_seq;
         if (ended) begin
            push_res(KIND_IGNORED, t, s, 0, 0, 0, 0, 0);
         end else if (behind(d)) begin
            cl = take_in_order(s, l, f, t);
            while (!cl && st_seq.size() > 0 && behind(st_seq[0] - next_seq)) begin
               cl = take_in_order(st_seq[0], st_len[0], st_flags[0], st_tag[0]);
               pop_store();
            end
            if (cl) begin
               ended = 1;
               msg_bytes = '0;
               while (st_seq.size() > 0) begin
                  push_res(KIND_IGNORED, st_tag[0], st_seq[0], 0, 0, 0, 0, 0);
                  pop_store();
               end
            end
         end else begin
            pos = 0;
            while (pos < st_seq.size() &&
                   ((st_seq[pos] - next_seq) ^ SIGN_BIT) < (d ^ SIGN_BIT))
               pos++;
            if (pos < st_seq.size() && st_seq[pos] == s && l <= st_len[pos] &&
                f == st_flags[pos]) begin
               push_res(KIND_DROPPED, t, s, 0, 0, 0, 0, 0);
            end else if (st_seq.size() >= REORDER_DEPTH) begin
               push_res(KIND_FULL, t, s, 0, 0, 0, 0, 0);
            end else begin
               st_seq.insert(pos, s); st_len.insert(pos, l);
               st_flags.insert(pos, f); st_tag.insert(pos, t);
               push_res(KIND_STASHED, t, s, 0, 0, 0, 0, 0);
            end
         end
         pending_results[pending_results.size() - 1].last = 1;
      endfunction

      task automatic check_result(segment_result_type got);
         segment_result_type w;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result tag %0d", got.tag));
            return;
         end
         w = pending_results.pop_front();
         if (got.kind !== w.kind)
            report_mismatch($sformatf("kind %0d want %0d", got.kind, w.kind));
         if (got.tag !== w.tag)
            report_mismatch($sformatf("tag %0d want %0d", got.tag, w.tag));
         if (got.seq !== w.seq)
            report_mismatch($sformatf("seq %h want %h", got.seq, w.seq));
         if (got.trim !== w.trim)
            report_mismatch($sformatf("trim %0d want %0d", got.trim, w.trim));
         if (got.useful !== w.useful)
            report_mismatch($sformatf("useful %0d want %0d", got.useful, w.useful));
         if (got.md !== w.md)
            report_mismatch($sformatf("message_done %b want %b", got.md, w.md));
         if (got.size !== w.size)
            report_mismatch($sformatf("message_size %0d want %0d", got.size, w.size));
         if (got.closed !== w.closed)
            report_mismatch($sformatf("closed %b want %b", got.closed, w.closed));
         if (got.last !== w.last)
            report_mismatch($sformatf("last %b want %b", got.last, w.last));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [31:0] req_seg_seq = '0;
   logic [15:0] req_seg_len = '0;
   logic [3:0] req_seg_flags = '0;
   logic [7:0] req_seg_tag = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_out_tag;
   logic [31:0] rsp_out_seq;
   logic [15:0] rsp_trim_bytes;
   logic [15:0] rsp_useful_len;
   logic rsp_message_done;
   logic [23:0] rsp_message_size;
   logic rsp_stream_closed;
   logic rsp_last;

   stream_segment_reorder_reassembly DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   reassembly_scoreboard board = new();

   // idling percentages; the hold-off switch forces a long receiver stall
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 0;
   int quiet_cycles = 0;

   // receiver: random stall, checks each result transfer
   always @(posedge clock) begin
      segment_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind; got.tag = rsp_out_tag; got.seq = rsp_out_seq;
         got.trim = rsp_trim_bytes; got.useful = rsp_useful_len;
         got.md = rsp_message_done; got.size = rsp_message_size;
         got.closed = rsp_stream_closed; got.last = rsp_last;
         board.check_result(got);
      end
      rsp_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("FAIL stream_segment_reorder_reassembly");
         $finish;
      end
   end

   // offer one segment and hold it until the transfer
   task automatic send_segment(input logic [31:0] s, input logic [15:0] l,
                               input logic [3:0] f, input logic [7:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_seg_seq <= s; req_seg_len <= l; req_seg_flags <= f; req_seg_tag <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_segment(s, l, f, t);
   endtask

   task automatic go_idle();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      go_idle();
      while (board.pending_results.size() != 0) @(posedge clock);
   endtask

   // flags without the close bit: the block never reopens
   // after a close, so random traffic avoids the close flag until the end
   function automatic logic [3:0] open_flags();
      return 4'($urandom_range(15)) & ~4'b0100;
   endfunction

   // one burst of in-window segments, shuffled, with some duplicates
   task automatic send_window(input int count, input bit small_len);
      logic [31:0] seqs[$];
      logic [15:0] lens[$];
      logic [31:0] p;
      int j;
      int k;
      p = board.next_seq;
      for (j = 0; j < count; j++) begin
         seqs.push_back(p);
         lens.push_back(small_len ? 16'($urandom_range(1, 40))
                                  : 16'($urandom_range(1, 65535)));
         p = p + lens[j];
      end
      for (j = 0; j < count; j++) begin
         k = $urandom_range(count - 1);
         if ($urandom_range(9) == 0) begin
            // noise: stale, overlapping or far ahead
            send_segment(seqs[k] - $urandom_range(0, 50), lens[k] + 16'($urandom_range(20)),
                         open_flags(), 8'($urandom));
         end else begin
            send_segment(seqs[k], lens[k], open_flags(), 8'($urandom));
         end
      end
      for (j = 0; j < count; j++)
         send_segment(seqs[j], lens[j], open_flags(), 8'($urandom));
   endtask

   initial begin
      int phase;
      int n;
      logic [31:0] b;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: in order, zero length with and without flags, flag bits other than close
      send_segment(32'd0, 16'd0, 4'd0, 8'h00);
      send_segment(32'd0, 16'd0, 4'b0001, 8'hFF);
      send_segment(32'd0, 16'd10, 4'b0010, 8'h01);
      send_segment(32'd5, 16'd20, 4'b1000, 8'h02);
      send_segment(32'd25, 16'd65535, 4'b0010, 8'h03);
      // stale and duplicate
      send_segment(32'd0, 16'd5, 4'd0, 8'h04);
      b = board.next_seq;
      // early segments, an early duplicate, then the filler drains them
      send_segment(b + 32'd100, 16'd10, 4'b0001, 8'h10);
      send_segment(b + 32'd100, 16'd5, 4'b0001, 8'h11);
      send_segment(b + 32'd50, 16'd50, 4'b0000, 8'h12);
      send_segment(b + 32'd60, 16'd10, 4'b0000, 8'h13);
      send_segment(b + 32'h7FFF_FFFF, 16'd1, 4'b0000, 8'h14);
      send_segment(b, 16'd50, 4'b0010, 8'h15);
      // far behind (negative distance)
      send_segment(b + 32'h8000_0000, 16'hFFFF, 4'b1111, 8'h16);
      // fill the store to the brim and overflow it
      b = board.next_seq;
      for (n = 1; n <= REORDER_DEPTH + 2; n++)
         send_segment(b + 32'(n * 10), 16'd10, 4'b0000, 8'(n));
      send_segment(b, 16'd10, 4'b0000, 8'h20);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            recv_hold = 1;
            repeat (300) @(posedge clock);
            recv_hold = 0;
         end
         send_window(12, 1);
      join
      wait_drained();

      // random phases: receiver idles most, then sender idles most, then neither
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 64 : 0;
         recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 25 : 0;
         for (n = 0; n < 7; n++)
            send_window($urandom_range(2, 8), $urandom_range(3) != 0);
         // a few wholly random descriptors near the current position
         for (n = 0; n < 6; n++)
            send_segment(board.next_seq + 32'($urandom_range(0, 200)) - 32'd100,
                         16'($urandom), open_flags(), 8'($urandom));
         wait_drained();
      end

      // close: stash a few, deliver the close, then post-end traffic
      b = board.next_seq;
      send_segment(b + 32'd40, 16'd5, 4'd0, 8'hA0);
      send_segment(b + 32'd90, 16'd5, 4'd0, 8'hA1);
      send_segment(b, 16'd30, 4'b0100, 8'hA2);
      send_segment(b + 32'd30, 16'd5, 4'b1111, 8'hA3);
      send_segment(32'hFFFF_FFFF, 16'hFFFF, 4'b1111, 8'hA4);
      wait_drained();
      repeat (50) @(posedge clock);

      if (error_count == 0)
         $display("PASS stream_segment_reorder_reassembly");
      else
         $display("FAIL stream_segment_reorder_reassembly");
      $finish;
   end

endmodule

FILE: stream_segment_reorder_reassembly.f
src/ssr_pkg.sv
src/ssr_cell.sv
src/stream_segment_reorder_reassembly.sv
bench/tb_top.sv
